FILE: hw/rtl/sfcd_pkg.sv
// shared types, constants and the digest step for the sensor frame checker
`default_nettype none
package sfcd_pkg;

   localparam logic [7:0] DIGEST_GEN    = 8'h83;
   localparam logic [7:0] DIGEST_KEY0   = 8'hEC;
   localparam logic [7:0] PREFIX_BYTE   = 8'hA5;
   localparam logic [9:0] ROW_BITS_OK   = 10'd68;
   localparam logic [3:0] RAW_BYTES     = 4'd9;
   localparam logic [3:0] CHECKED_BYTES = 4'd6;
   localparam int         SIGN_BIT      = 3;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_BAD_LENGTH = 3'd1;
   localparam logic [2:0] STATUS_BAD_PREFIX = 3'd2;
   localparam logic [2:0] STATUS_BAD_SUM    = 3'd3;
   localparam logic [2:0] STATUS_BAD_DIGEST = 3'd4;

   typedef struct packed {
      logic [7:0] row_byte;
      logic [9:0] row_bits;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [7:0]        sensor_id;
      logic signed [11:0] temperature_tenths;
   } rsp_item_type;

   // one byte through the reflected galois lfsr digest, msb first
   // returns {accumulator, key}
   function automatic logic [15:0] digest_byte(input logic [7:0] acc_in,
                                               input logic [7:0] key_in,
                                               input logic [7:0] data);
      logic [7:0] acc;
      logic [7:0] key;
      acc = acc_in;
      key = key_in;
      for (int i = 7; i >= 0; i--) begin
         if (data[i]) acc = acc ^ key;
         if (key[0]) key = (key >> 1) ^ DIGEST_GEN;
         else key = key >> 1;
      end
      return {acc, key};
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sfcd_if.sv
// valid/ready channel interfaces for row bytes and decoded results
`default_nettype none
interface sfcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] row_byte;
   logic [9:0] row_bits;
   logic       last_byte;
   modport source (output valid, output row_byte, output row_bits, output last_byte,
                   input ready);
   modport sink (input valid, input row_byte, input row_bits, input last_byte,
                 output ready);
endinterface

interface sfcd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [7:0]         sensor_id;
   logic signed [11:0] temperature_tenths;
   modport source (output valid, output status, output sensor_id,
                   output temperature_tenths, input ready);
   modport sink (input valid, input status, input sensor_id,
                 input temperature_tenths, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sensor_frame_check_decode_top.sv
// a row's last byte is held in the input register, and its result is then loaded into the result register
// throughput: one byte per cycle; a last byte waits only while the result
//   register holds an untaken result
// reset (synchronous, active high) empties both registers and restarts the row
// with the digest key at its start value
`default_nettype none
module sensor_frame_check_decode_top
   import sfcd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sfcd_req_if.sink   req_bus,
   sfcd_rsp_if.source rsp_bus
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         advance;
   logic         out_free;
   rsp_item_type result;

   // a byte that ends no row never needs the result register
   assign advance       = in_valid_ff && (!in_item_ff.last_byte || out_free);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_item_ff <= '{row_byte: req_bus.row_byte, row_bits: req_bus.row_bits,
                         last_byte: req_bus.last_byte};
      end
   end

   sfcd_row_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   sfcd_rsp_reg u_rsp (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && in_item_ff.last_byte),
      .result  (result),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/sfcd_row_core.sv
// per-row state: prefix, nibble alignment, sum and digest checks, result decode
`default_nettype none
module sfcd_row_core
   import sfcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   logic [3:0]  byte_index_ff, byte_index_in;
   logic [7:0]  previous_byte_ff, previous_byte_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  digest_ff, digest_in;
   logic [7:0]  key_ff, key_in;
   logic        prefix_bad_ff, prefix_bad_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic        negative_ff, negative_in;
   logic [11:0] bcd_ff, bcd_in;
   logic [2:0]  fail_ff, fail_in;

   logic [7:0]  aligned;
   logic [3:0]  apos;
   logic [15:0] digest_next;
   logic [10:0] magnitude;
   logic [11:0] magnitude_ext;
   logic [2:0]  status;

   // aligned byte straddles the previous and current raw bytes
   assign aligned     = {previous_byte_ff[3:0], item.row_byte[7:4]};
   assign apos        = byte_index_ff - 4'd1;
   assign digest_next = digest_byte(digest_ff, key_ff, aligned);

   always_comb begin
      byte_index_in    = byte_index_ff;
      previous_byte_in = previous_byte_ff;
      sum_in           = sum_ff;
      digest_in        = digest_ff;
      key_in           = key_ff;
      prefix_bad_in    = prefix_bad_ff;
      held_id_in       = held_id_ff;
      negative_in      = negative_ff;
      bcd_in           = bcd_ff;
      fail_in          = fail_ff;
      if (byte_index_ff < RAW_BYTES) begin
         if (byte_index_ff == 4'd0) begin
            prefix_bad_in = (item.row_byte != PREFIX_BYTE);
         end else begin
            if (apos < CHECKED_BYTES) begin
               sum_in    = sum_ff + aligned;
               digest_in = digest_next[15:8];
               key_in    = digest_next[7:0];
            end else if (apos == CHECKED_BYTES) begin
               if (aligned != sum_ff && fail_ff == STATUS_OK) fail_in = STATUS_BAD_SUM;
            end else begin
               if (aligned != digest_ff && fail_ff == STATUS_OK) fail_in = STATUS_BAD_DIGEST;
            end
            if (apos == 4'd1) held_id_in = aligned;
         end
         if (byte_index_ff == 4'd3) negative_in = item.row_byte[SIGN_BIT];
         if (byte_index_ff == 4'd4) bcd_in = {item.row_byte, 4'd0};
         if (byte_index_ff == 4'd5) bcd_in = {bcd_ff[11:4], item.row_byte[7:4]};
         previous_byte_in = item.row_byte;
         byte_index_in    = byte_index_ff + 4'd1;
      end
   end

   always_comb begin
      if (item.row_bits != ROW_BITS_OK || byte_index_in < RAW_BYTES) status = STATUS_BAD_LENGTH;
      else if (prefix_bad_in) status = STATUS_BAD_PREFIX;
      else status = fail_in;
   end

   assign magnitude = {7'd0, bcd_in[11:8]} * 11'd100
                    + {7'd0, bcd_in[7:4]} * 11'd10
                    + {7'd0, bcd_in[3:0]};
   assign magnitude_ext = {1'b0, magnitude};

   always_comb begin
      result.status = status;
      result.sensor_id = '0;
      result.temperature_tenths = '0;
      if (status == STATUS_OK) begin
         result.sensor_id = held_id_in;
         result.temperature_tenths = negative_in ? $signed(12'd0 - magnitude_ext)
                                                 : $signed(magnitude_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last_byte)) begin
         byte_index_ff    <= '0;
         previous_byte_ff <= '0;
         sum_ff           <= '0;
         digest_ff        <= '0;
         key_ff           <= DIGEST_KEY0;
         prefix_bad_ff    <= 1'b0;
         held_id_ff       <= '0;
         negative_ff      <= 1'b0;
         bcd_ff           <= '0;
         fail_ff          <= STATUS_OK;
      end else if (advance) begin
         byte_index_ff    <= byte_index_in;
         previous_byte_ff <= previous_byte_in;
         sum_ff           <= sum_in;
         digest_ff        <= digest_in;
         key_ff           <= key_in;
         prefix_bad_ff    <= prefix_bad_in;
         held_id_ff       <= held_id_in;
         negative_ff      <= negative_in;
         bcd_ff           <= bcd_in;
         fail_ff          <= fail_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/sfcd_rsp_reg.sv
// result register that drives the response channel
`default_nettype none
module sfcd_rsp_reg
   import sfcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire rsp_item_type result,
   output logic              free,
   sfcd_rsp_if.source        rsp_bus
);

   logic         valid_ff;
   rsp_item_type data_ff;

   assign free = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= result;
   end

   assign rsp_bus.valid              = valid_ff;
   assign rsp_bus.status             = data_ff.status;
   assign rsp_bus.sensor_id          = data_ff.sensor_id;
   assign rsp_bus.temperature_tenths = data_ff.temperature_tenths;

endmodule
`default_nettype wire

FILE: hw/rtl/sfcd_checker.sv
// port-level assertions for the sensor frame checker and their bind
`default_nettype none
module sfcd_checker
   import sfcd_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [2:0]        status,
   input wire logic [7:0]        sensor_id,
   input wire logic signed [11:0] temperature_tenths
);

   // a stalled result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(sensor_id)
                                  && $stable(temperature_tenths))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("result valid or input not ready right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= STATUS_BAD_DIGEST)
      else $error("status code out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STATUS_OK |-> sensor_id == 8'd0 && temperature_tenths == 12'sd0)
      else $error("failed row carries id or temperature");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> temperature_tenths <= 12'sd1665 && temperature_tenths >= -12'sd1665)
      else $error("temperature out of range");

endmodule

bind sensor_frame_check_decode_top sfcd_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .status             (rsp_bus.status),
   .sensor_id          (rsp_bus.sensor_id),
   .temperature_tenths (rsp_bus.temperature_tenths)
);
`default_nettype wire

FILE: tb/tb_sensor_frame_check_decode_top.sv
// testbench for the sensor frame checker: row stimulus, row decode prediction, result checks
module tb_sensor_frame_check_decode_top;
   import sfcd_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1100;

   logic clock;
   logic reset;

   sfcd_req_if req_bus ();
   sfcd_rsp_if rsp_bus ();

   sensor_frame_check_decode_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // row bytes waiting to be sent and decoded results waiting to arrive
   req_item_type row_bytes_pending[$];
   rsp_item_type expected_rows[$];
   logic [7:0]   row_raw[0:8];
   int           queued_items;
   int           fail_count;

   // decoder state as the block should hold it
   logic [3:0]  row_pos;
   logic [7:0]  last_raw;
   logic [7:0]  run_sum;
   logic [7:0]  run_digest;
   logic [7:0]  run_key;
   logic        lead_bad;
   logic [7:0]  id_hold;
   logic        minus;
   logic [11:0] digits;
   logic [2:0]  fail_code;

   // driver and monitor state
   req_item_type next_byte;
   logic         byte_taken;
   int           send_gap;
   int           take_stall;
   bit           send_calm;
   bit           take_calm;
   int           idle_cycles;

   function automatic void digest_fold(inout logic [7:0] acc, inout logic [7:0] key,
                                       input logic [7:0] data);
      int n;
      for (n = 0; n < 8; n++) begin
         if (data[7 - n]) acc = acc ^ key;
         key = key[0] ? ((key >> 1) ^ DIGEST_GEN) : (key >> 1);
      end
   endfunction

   function automatic void clear_row_state();
      row_pos = '0;
      last_raw = '0;
      run_sum = '0;
      run_digest = '0;
      run_key = DIGEST_KEY0;
      lead_bad = 1'b0;
      id_hold = '0;
      minus = 1'b0;
      digits = '0;
      fail_code = STATUS_OK;
   endfunction

   function automatic void absorb_row_byte(input logic [7:0] b, input logic [9:0] bits,
                                           input logic last);
      logic [7:0]   aligned;
      logic [3:0]   apos;
      int           t;
      rsp_item_type res;
      if (row_pos < RAW_BYTES) begin
         if (row_pos == 4'd0) begin
            lead_bad = (b != PREFIX_BYTE);
         end else begin
            aligned = {last_raw[3:0], b[7:4]};
            apos = row_pos - 4'd1;
            if (apos < CHECKED_BYTES) begin
               run_sum = run_sum + aligned;
               digest_fold(run_digest, run_key, aligned);
            end else if (apos == CHECKED_BYTES) begin
               if (aligned != run_sum && fail_code == STATUS_OK) fail_code = STATUS_BAD_SUM;
            end else begin
               if (aligned != run_digest && fail_code == STATUS_OK)
                  fail_code = STATUS_BAD_DIGEST;
            end
            if (apos == 4'd1) id_hold = aligned;
         end
         if (row_pos == 4'd3) minus = b[SIGN_BIT];
         if (row_pos == 4'd4) digits = {b, 4'h0};
         if (row_pos == 4'd5) digits[3:0] = b[7:4];
         last_raw = b;
         row_pos = row_pos + 4'd1;
      end
      if (last) begin
         res = '0;
         if (bits != ROW_BITS_OK || row_pos < RAW_BYTES) res.status = STATUS_BAD_LENGTH;
         else if (lead_bad) res.status = STATUS_BAD_PREFIX;
         else res.status = fail_code;
         if (res.status == STATUS_OK) begin
            // nibbles above 9 keep their plain weight
            t = digits[11:8] * 100 + digits[7:4] * 10 + digits[3:0];
            if (minus) t = -t;
            res.temperature_tenths = t[11:0];
            res.sensor_id = id_hold;
         end
         expected_rows.push_back(res);
         clear_row_state();
      end
   endfunction

   function automatic void check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_rows.size() == 0) begin
         $error("result with no row pending: status %0d", got.status);
         fail_count++;
      end else begin
         want = expected_rows.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
         end
         if (got.sensor_id !== want.sensor_id) begin
            $error("sensor_id: expected %0d, got %0d", want.sensor_id, got.sensor_id);
            fail_count++;
         end
         if (got.temperature_tenths !== want.temperature_tenths) begin
            $error("temperature_tenths: expected %0d, got %0d",
                   $signed(want.temperature_tenths), $signed(got.temperature_tenths));
            fail_count++;
         end
      end
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic fill_row(input logic [7:0] lead);
      int i;
      for (i = 0; i < 9; i++) row_raw[i] = 8'($urandom_range(0, 255));
      row_raw[0] = lead;
   endtask

   // place sum and digest of aligned bytes 0..5 into the tail of the row
   task automatic seal_row(input bit spoil_sum, input bit spoil_digest);
      logic [7:0] a;
      logic [7:0] s;
      logic [7:0] d;
      logic [7:0] k;
      int         i;
      s = '0;
      d = '0;
      k = DIGEST_KEY0;
      for (i = 0; i < 6; i++) begin
         a = {row_raw[i][3:0], row_raw[i + 1][7:4]};
         s = s + a;
         digest_fold(d, k, a);
      end
      if (spoil_sum) s = s ^ 8'($urandom_range(1, 255));
      if (spoil_digest) d = d ^ 8'($urandom_range(1, 255));
      row_raw[6][3:0] = s[7:4];
      row_raw[7] = {s[3:0], d[7:4]};
      row_raw[8][7:4] = d[3:0];
   endtask

   task automatic push_row(input int length, input logic [9:0] bit_count);
      req_item_type it;
      int           i;
      for (i = 0; i < length; i++) begin
         it.row_byte = (i < 9) ? row_raw[i] : 8'($urandom_range(0, 255));
         it.row_bits = bit_count;
         it.last_byte = (i == length - 1);
         row_bytes_pending.push_back(it);
      end
      queued_items += length;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || byte_taken) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (row_bytes_pending.size() > 0) begin
            next_byte = row_bytes_pending.pop_front();
            req_bus.row_byte <= next_byte.row_byte;
            req_bus.row_bits <= next_byte.row_bits;
            req_bus.last_byte <= next_byte.last_byte;
            req_bus.valid <= 1'b1;
            send_gap <= send_calm ? 0 : gap_len();
            if ($urandom_range(0, 249) == 0) send_calm <= !send_calm;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (take_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         take_stall <= take_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!take_calm && $urandom_range(0, 3) == 0) take_stall <= gap_len();
         if ($urandom_range(0, 499) == 0) take_calm <= !take_calm;
      end
   end

   // monitor: predict on each byte transaction, check each result transaction
   always @(posedge clock) begin
      if (reset) begin
         byte_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         byte_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready)
            absorb_row_byte(req_bus.row_byte, req_bus.row_bits, req_bus.last_byte);
         if (rsp_bus.valid && rsp_bus.ready)
            check_result('{rsp_bus.status, rsp_bus.sensor_id, rsp_bus.temperature_tenths});
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else if (row_bytes_pending.size() > 0 || req_bus.valid ||
                      expected_rows.size() > 0) begin
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
               $display("tb_sensor_frame_check_decode_top: FAIL");
               $finish;
            end
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int       r;
      int       length;
      logic [9:0] bits;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.row_byte = '0;
      req_bus.row_bits = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      send_gap = 0;
      take_stall = 0;
      send_calm = 1'b0;
      take_calm = 1'b0;
      byte_taken = 1'b0;
      idle_cycles = 0;
      queued_items = 0;
      fail_count = 0;
      clear_row_state();

      // good row, negative sign, all-F digits
      fill_row(PREFIX_BYTE);
      row_raw[3] = 8'hFF;
      row_raw[4] = 8'hFF;
      row_raw[5] = 8'hFF;
      seal_row(1'b0, 1'b0);
      push_row(9, ROW_BITS_OK);
      // lone last byte with the largest bit count
      row_raw[0] = 8'h00;
      push_row(1, 10'h3FF);
      // long row with a bad prefix
      fill_row(8'h00);
      seal_row(1'b0, 1'b0);
      push_row(10, ROW_BITS_OK);
      // short row with the right bit count
      fill_row(PREFIX_BYTE);
      push_row(3, ROW_BITS_OK);

      while (queued_items < RANDOM_ITEMS + 23) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            fill_row(PREFIX_BYTE);
            seal_row(1'b0, 1'b0);
            push_row(9, ROW_BITS_OK);
         end else if (r < 74) begin
            // sum, digest or both spoiled
            fill_row(PREFIX_BYTE);
            seal_row(r < 66 || r >= 71, r >= 63);
            push_row(9, ROW_BITS_OK);
         end else if (r < 78) begin
            fill_row(8'($urandom_range(0, 255)));
            seal_row(1'($urandom_range(0, 1)), 1'b0);
            push_row(9, ROW_BITS_OK);
         end else if (r < 83) begin
            fill_row(PREFIX_BYTE);
            seal_row(1'b0, 1'b0);
            bits = $urandom_range(0, 1) ? (ROW_BITS_OK + ($urandom_range(0, 1) ? 10'd1 : -10'd1))
                                        : 10'($urandom_range(0, 1023));
            push_row(9, bits);
         end else if (r < 88) begin
            fill_row(PREFIX_BYTE);
            seal_row(1'b0, 1'b0);
            push_row($urandom_range(1, 8), ROW_BITS_OK);
         end else if (r < 93) begin
            fill_row(PREFIX_BYTE);
            seal_row(1'($urandom_range(0, 1)), 1'b0);
            push_row($urandom_range(10, 15), ROW_BITS_OK);
         end else begin
            fill_row(8'($urandom_range(0, 255)));
            length = $urandom_range(1, 12);
            push_row(length, 10'($urandom_range(0, 1023)));
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (row_bytes_pending.size() > 0 || req_bus.valid || expected_rows.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_sensor_frame_check_decode_top: PASS");
      end else begin
         $display("tb_sensor_frame_check_decode_top: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/sfcd_pkg.sv
hw/rtl/sfcd_if.sv
hw/rtl/sfcd_row_core.sv
hw/rtl/sfcd_rsp_reg.sv
hw/rtl/sensor_frame_check_decode_top.sv
hw/rtl/sfcd_checker.sv
tb/tb_sensor_frame_check_decode_top.sv
